FILE: sv/aqbg_pkg.sv
`timescale 1ns / 1ps

package aqbg_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    localparam int TIME_W     = 48;
    localparam int BYTES_W    = 24;
    localparam int SUM_W      = 40;
    localparam int Q_W        = 7;
    localparam int TARGET_W   = 20;
    localparam int COOL_W     = 16;
    localparam int WIN_W      = 32;
    localparam int FRAMES_W   = 32;
    localparam int ENTRY_W    = TIME_W + BYTES_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int SPLIT_W = 24;
    localparam int TK_W    = 27;
    localparam int MUL_W   = TK_W + SPLIT_W;
    localparam int CMP_W   = 64;

    localparam logic [TARGET_W-1:0] LHS_SCALE   = TARGET_W'(800000);
    localparam logic [Q_W-1:0]      DOWN_PCT    = Q_W'(115);
    localparam logic [Q_W-1:0]      UP_PCT      = Q_W'(85);
    localparam logic [TIME_W-1:0]   MIN_SPAN_US = TIME_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_KBPS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUALITY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUALITY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUALITY_STEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_FRAMES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_US       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_QUALITY = 3'd7;

    localparam logic [Q_W-1:0]    RST_MIN_QUALITY     = Q_W'(10);
    localparam logic [Q_W-1:0]    RST_MAX_QUALITY     = Q_W'(95);
    localparam logic [Q_W-1:0]    RST_QUALITY_STEP    = Q_W'(5);
    localparam logic [COOL_W-1:0] RST_COOLDOWN_FRAMES = COOL_W'(5);
    localparam logic [WIN_W-1:0]  RST_WINDOW_US       = WIN_W'(1000000);
    localparam logic [Q_W-1:0]    RST_INITIAL_QUALITY = Q_W'(80);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_READ,
        OP_DROP,
        OP_APPEND,
        OP_SPAN,
        OP_MUL_L0,
        OP_MUL_L1,
        OP_MUL_HI0,
        OP_MUL_HI1,
        OP_MUL_LO0,
        OP_MUL_LO1,
        OP_DECIDE
    } dp_op_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic prune_hit;
        logic out_busy;
    } dp_status_t;

endpackage

FILE: sv/adaptive_quality_bandwidth_governor_top.sv
`timescale 1ns / 1ps
// Each frame runs through the control states in order: the oldest entry is read through the
// single read port of the window memory and dropped while it has expired, up to the window
// depth, then the new entry is appended, the oldest is read again for the span, six multiply
// steps follow and the decision waits for the last result to be taken; input stalls meanwhile.
// Reset clears the window, counters and result valid flag at once; configuration registers return
// to their defaults and the quality to the initial quality. No clearing pass is needed.

module adaptive_quality_bandwidth_governor_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [aqbg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aqbg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [aqbg_pkg::TIME_W-1:0]      time_us,
    input  logic [aqbg_pkg::BYTES_W-1:0]     byte_count,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [aqbg_pkg::Q_W-1:0]         quality,
    output logic                             quality_changed,
    output logic [aqbg_pkg::SUM_W-1:0]       window_bytes,
    output logic [aqbg_pkg::CNT_W-1:0]       window_entries
);
    import aqbg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    aqbg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    aqbg_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .time_us         (time_us),
        .byte_count      (byte_count),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .quality         (quality),
        .quality_changed (quality_changed),
        .window_bytes    (window_bytes),
        .window_entries  (window_entries)
    );

endmodule

FILE: sv/aqbg_ctrl.sv
`timescale 1ns / 1ps

module aqbg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  aqbg_pkg::dp_status_t status,
    output aqbg_pkg::dp_cmd_t    cmd
);
    import aqbg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PR_RD,
        S_PR_CHK,
        S_DROP,
        S_APPEND,
        S_AD_RD,
        S_SPAN,
        S_MUL_L0,
        S_MUL_L1,
        S_MUL_HI0,
        S_MUL_HI1,
        S_MUL_LO0,
        S_MUL_LO1,
        S_WAIT_OUT,
        S_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;
    dp_op_t op_reg;
    logic   stall_reg;

    function automatic dp_op_t op_for(input state_t s);
        dp_op_t op;
        unique case (s)
            S_PR_RD:   op = OP_READ;
            S_DROP:    op = OP_DROP;
            S_APPEND:  op = OP_APPEND;
            S_AD_RD:   op = OP_READ;
            S_SPAN:    op = OP_SPAN;
            S_MUL_L0:  op = OP_MUL_L0;
            S_MUL_L1:  op = OP_MUL_L1;
            S_MUL_HI0: op = OP_MUL_HI0;
            S_MUL_HI1: op = OP_MUL_HI1;
            S_MUL_LO0: op = OP_MUL_LO0;
            S_MUL_LO1: op = OP_MUL_LO1;
            S_DECIDE:  op = OP_DECIDE;
            default:   op = OP_NONE;
        endcase
        return op;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_PR_RD;
            S_PR_RD:    state_next = S_PR_CHK;
            S_PR_CHK:   state_next = status.prune_hit ? S_DROP : S_APPEND;
            S_DROP:     state_next = S_PR_RD;
            S_APPEND:   state_next = S_AD_RD;
            S_AD_RD:    state_next = S_SPAN;
            S_SPAN:     state_next = S_MUL_L0;
            S_MUL_L0:   state_next = S_MUL_L1;
            S_MUL_L1:   state_next = S_MUL_HI0;
            S_MUL_HI0:  state_next = S_MUL_HI1;
            S_MUL_HI1:  state_next = S_MUL_LO0;
            S_MUL_LO0:  state_next = S_MUL_LO1;
            S_MUL_LO1:  state_next = S_WAIT_OUT;
            S_WAIT_OUT: if (!status.out_busy) state_next = S_DECIDE;
            S_DECIDE:   state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_NONE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_for(state_next);
            stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = stall_reg;
    assign cmd.load = in_valid && !stall_reg;
    assign cmd.op   = op_reg;

endmodule

FILE: sv/aqbg_dp.sv
`timescale 1ns / 1ps

module aqbg_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [aqbg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aqbg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [aqbg_pkg::TIME_W-1:0]      time_us,
    input  logic [aqbg_pkg::BYTES_W-1:0]     byte_count,
    input  aqbg_pkg::dp_cmd_t                cmd,
    output aqbg_pkg::dp_status_t             status,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [aqbg_pkg::Q_W-1:0]         quality,
    output logic                             quality_changed,
    output logic [aqbg_pkg::SUM_W-1:0]       window_bytes,
    output logic [aqbg_pkg::CNT_W-1:0]       window_entries
);
    import aqbg_pkg::*;

    logic                adapt_en_reg;
    logic [TARGET_W-1:0] target_reg;
    logic [Q_W-1:0]      qmin_reg;
    logic [Q_W-1:0]      qmax_reg;
    logic [Q_W-1:0]      step_reg;
    logic [COOL_W-1:0]   cooldown_reg;
    logic [WIN_W-1:0]    window_reg;

    logic [ENTRY_W-1:0]  entry_mem [WINDOW_DEPTH];
    logic [ENTRY_W-1:0]  rd_q;

    logic [PTR_W-1:0]    head_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic [FRAMES_W-1:0] last_adapt_reg;
    logic [Q_W-1:0]      quality_reg;

    logic [TIME_W-1:0]   now_reg;
    logic [BYTES_W-1:0]  bytes_reg;
    logic [TIME_W-1:0]   span_reg;
    logic [TK_W-1:0]     tk_dn_reg;
    logic [TK_W-1:0]     tk_up_reg;
    logic [CMP_W-1:0]    lhs_reg;
    logic [CMP_W-1:0]    r_dn_reg;
    logic [CMP_W-1:0]    r_up_reg;

    logic                out_valid_reg;
    logic [Q_W-1:0]      out_q_reg;
    logic                out_chg_reg;
    logic [SUM_W-1:0]    out_bytes_reg;
    logic [CNT_W-1:0]    out_entries_reg;

    logic [TIME_W-1:0]   rd_time;
    logic [BYTES_W-1:0]  rd_bytes;
    logic [TIME_W-1:0]   age;
    logic                full;
    logic [PTR_W:0]      tail_sum;
    logic [PTR_W-1:0]    tail_idx;
    logic [PTR_W-1:0]    head_inc;
    logic [TIME_W-1:0]   span_raw;
    logic [TK_W-1:0]     mul_a;
    logic [SPLIT_W-1:0]  mul_b;
    logic [MUL_W-1:0]    prod;
    logic [CMP_W-1:0]    prod_lo;
    logic [CMP_W-1:0]    prod_hi;
    logic                gate;
    logic                down_ok;
    logic                up_ok;
    logic                changed;
    logic [Q_W:0]        q_dn;
    logic [Q_W:0]        q_up;
    logic [Q_W-1:0]      q_new;

    assign rd_time  = rd_q[ENTRY_W-1:BYTES_W];
    assign rd_bytes = rd_q[BYTES_W-1:0];
    assign age      = now_reg - rd_time;
    assign full     = (count_reg == CNT_W'(WINDOW_DEPTH));
    assign tail_sum = (PTR_W + 1)'(head_reg) + (PTR_W + 1)'(count_reg);
    assign tail_idx = (tail_sum >= (PTR_W + 1)'(WINDOW_DEPTH))
                      ? PTR_W'(tail_sum - (PTR_W + 1)'(WINDOW_DEPTH))
                      : tail_sum[PTR_W-1:0];
    assign head_inc = (head_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign status.prune_hit = (count_reg != '0) && (now_reg > rd_time)
                              && (age > TIME_W'(window_reg));
    assign status.out_busy  = out_valid_reg;

    assign span_raw = (now_reg > rd_time) ? age : '0;

    always_comb
    begin
        mul_a = TK_W'(LHS_SCALE);
        mul_b = sum_reg[SPLIT_W-1:0];
        case (cmd.op)
            OP_MUL_L1:  mul_b = SPLIT_W'(sum_reg[SUM_W-1:SPLIT_W]);
            OP_MUL_HI0:
            begin
                mul_a = tk_dn_reg;
                mul_b = span_reg[SPLIT_W-1:0];
            end
            OP_MUL_HI1:
            begin
                mul_a = tk_dn_reg;
                mul_b = span_reg[TIME_W-1:SPLIT_W];
            end
            OP_MUL_LO0:
            begin
                mul_a = tk_up_reg;
                mul_b = span_reg[SPLIT_W-1:0];
            end
            OP_MUL_LO1:
            begin
                mul_a = tk_up_reg;
                mul_b = span_reg[TIME_W-1:SPLIT_W];
            end
            default:
            begin
                mul_a = TK_W'(LHS_SCALE);
                mul_b = sum_reg[SPLIT_W-1:0];
            end
        endcase
    end

    assign prod    = MUL_W'(mul_a) * MUL_W'(mul_b);
    assign prod_lo = CMP_W'(prod);
    assign prod_hi = {prod[CMP_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}};

    assign gate = adapt_en_reg && (target_reg != '0) && (count_reg >= CNT_W'(2))
                  && ({1'b0, frames_reg} >= ({1'b0, last_adapt_reg}
                                             + (FRAMES_W + 1)'(cooldown_reg)));
    assign down_ok = (lhs_reg > r_dn_reg) && (quality_reg > qmin_reg);
    assign up_ok   = (lhs_reg < r_up_reg) && (quality_reg < qmax_reg);
    assign changed = gate && (down_ok || up_ok);

    assign q_dn = {1'b0, quality_reg} - {1'b0, step_reg};
    assign q_up = {1'b0, quality_reg} + {1'b0, step_reg};

    always_comb
    begin
        if (down_ok)
        begin
            q_new = (q_dn[Q_W] || (q_dn[Q_W-1:0] < qmin_reg)) ? qmin_reg : q_dn[Q_W-1:0];
        end
        else
        begin
            q_new = (q_up > {1'b0, qmax_reg}) ? qmax_reg : q_up[Q_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adapt_en_reg   <= 1'b0;
            target_reg     <= '0;
            qmin_reg       <= RST_MIN_QUALITY;
            qmax_reg       <= RST_MAX_QUALITY;
            step_reg       <= RST_QUALITY_STEP;
            cooldown_reg   <= RST_COOLDOWN_FRAMES;
            window_reg     <= RST_WINDOW_US;
            quality_reg    <= RST_INITIAL_QUALITY;
            last_adapt_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_ADAPT_ENABLE:    adapt_en_reg <= cfg_data[0];
                    CFG_TARGET_KBPS:     target_reg   <= cfg_data[TARGET_W-1:0];
                    CFG_MIN_QUALITY:     qmin_reg     <= cfg_data[Q_W-1:0];
                    CFG_MAX_QUALITY:     qmax_reg     <= cfg_data[Q_W-1:0];
                    CFG_QUALITY_STEP:    step_reg     <= cfg_data[Q_W-1:0];
                    CFG_COOLDOWN_FRAMES: cooldown_reg <= cfg_data[COOL_W-1:0];
                    CFG_WINDOW_US:       window_reg   <= cfg_data[WIN_W-1:0];
                    CFG_INITIAL_QUALITY: quality_reg  <= cfg_data[Q_W-1:0];
                    default: ;
                endcase
            end
            if ((cmd.op == OP_DECIDE) && changed)
            begin
                quality_reg    <= q_new;
                last_adapt_reg <= frames_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            frames_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_DROP:
                begin
                    sum_reg   <= sum_reg - SUM_W'(rd_bytes);
                    head_reg  <= head_inc;
                    count_reg <= count_reg - 1'b1;
                end
                OP_APPEND:
                begin
                    if (frames_reg != '1)
                    begin
                        frames_reg <= frames_reg + 1'b1;
                    end
                    if (full)
                    begin
                        head_reg <= head_inc;
                        sum_reg  <= sum_reg - SUM_W'(rd_bytes) + SUM_W'(bytes_reg);
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        sum_reg   <= sum_reg + SUM_W'(bytes_reg);
                    end
                end
                default: ;
            endcase
            if (cmd.op == OP_DECIDE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg   <= time_us;
            bytes_reg <= byte_count;
        end
        if (cmd.op == OP_APPEND)
        begin
            entry_mem[tail_idx] <= {now_reg, bytes_reg};
        end
        if (cmd.op == OP_READ)
        begin
            rd_q <= entry_mem[head_reg];
        end
        case (cmd.op)
            OP_SPAN:
            begin
                span_reg  <= (span_raw < MIN_SPAN_US) ? MIN_SPAN_US : span_raw;
                tk_dn_reg <= TK_W'(target_reg) * TK_W'(DOWN_PCT);
                tk_up_reg <= TK_W'(target_reg) * TK_W'(UP_PCT);
            end
            OP_MUL_L0:  lhs_reg  <= prod_lo;
            OP_MUL_L1:  lhs_reg  <= lhs_reg + prod_hi;
            OP_MUL_HI0: r_dn_reg <= prod_lo;
            OP_MUL_HI1: r_dn_reg <= r_dn_reg + prod_hi;
            OP_MUL_LO0: r_up_reg <= prod_lo;
            OP_MUL_LO1: r_up_reg <= r_up_reg + prod_hi;
            default: ;
        endcase
        if (cmd.op == OP_DECIDE)
        begin
            out_q_reg       <= changed ? q_new : quality_reg;
            out_chg_reg     <= changed;
            out_bytes_reg   <= sum_reg;
            out_entries_reg <= count_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign quality         = out_q_reg;
    assign quality_changed = out_chg_reg;
    assign window_bytes    = out_bytes_reg;
    assign window_entries  = out_entries_reg;

    a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DROP) |-> (count_reg != '0))
        else $error("entry dropped from an empty window");

    a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DROP) |=> (count_reg == CNT_W'($past(count_reg) - 1'b1)))
        else $error("window count did not follow a drop");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(cmd.op) == OP_DECIDE))
        else $error("result raised without a decision");

    a_adapt_mark: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == OP_DECIDE) && changed) |=> (last_adapt_reg == frames_reg))
        else $error("adaptation did not record the frame count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_APPEND) |=> (count_reg <= CNT_W'(WINDOW_DEPTH))
                                  && (count_reg != '0))
        else $error("window count out of range after append");

endmodule

FILE: tb/sv/governor_check.sv
`timescale 1ns / 1ps

module governor_check
    import aqbg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [TIME_W-1:0]     time_us,
    input  logic [BYTES_W-1:0]    byte_count,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [Q_W-1:0]        quality,
    input  logic                  quality_changed,
    input  logic [SUM_W-1:0]      window_bytes,
    input  logic [CNT_W-1:0]      window_entries,
    output int                    mismatches,
    output int                    reports_pending
);

    typedef struct packed {
        logic [Q_W-1:0]   quality;
        logic             changed;
        logic [SUM_W-1:0] bytes;
        logic [CNT_W-1:0] entries;
    } frame_report_t;

    logic                adapt_on;
    logic [TARGET_W-1:0] target;
    logic [Q_W-1:0]      q_min;
    logic [Q_W-1:0]      q_max;
    logic [Q_W-1:0]      q_step;
    logic [COOL_W-1:0]   cooldown;
    logic [WIN_W-1:0]    window;

    logic [TIME_W-1:0]   stamp_mem [WINDOW_DEPTH];
    logic [BYTES_W-1:0]  size_mem [WINDOW_DEPTH];
    logic [PTR_W-1:0]    head;
    logic [CNT_W-1:0]    held;
    logic [SUM_W-1:0]    sum;
    logic [FRAMES_W-1:0] sent;
    logic [FRAMES_W-1:0] adapted_at;
    logic [Q_W-1:0]      q_now;

    frame_report_t       reports_due [16];
    logic [3:0]          put_idx;
    logic [3:0]          take_idx;
    frame_report_t       seen;
    frame_report_t       want;

    function void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ADAPT_ENABLE:    adapt_on = data[0];
            CFG_TARGET_KBPS:     target = data[TARGET_W-1:0];
            CFG_MIN_QUALITY:     q_min = data[Q_W-1:0];
            CFG_MAX_QUALITY:     q_max = data[Q_W-1:0];
            CFG_QUALITY_STEP:    q_step = data[Q_W-1:0];
            CFG_COOLDOWN_FRAMES: cooldown = data[COOL_W-1:0];
            CFG_WINDOW_US:       window = data[WIN_W-1:0];
            CFG_INITIAL_QUALITY: q_now = data[Q_W-1:0];
            default: ;
        endcase
    endfunction

    function void evict_oldest();
        sum  = sum - SUM_W'(size_mem[head]);
        head = PTR_W'((int'(head) + 1) % WINDOW_DEPTH);
        held = held - 1'b1;
    endfunction

    function frame_report_t predict_frame_result(logic [TIME_W-1:0] now,
                                                 logic [BYTES_W-1:0] size);
        logic [TIME_W-1:0] first;
        logic [63:0]       span;
        logic [63:0]       wide_sum;
        logic [63:0]       above;
        logic [63:0]       below;
        logic [PTR_W-1:0]  tail;
        logic              stepped;
        int                q;
        frame_report_t     r;
        stepped = 1'b0;
        while (held != 0 && now > stamp_mem[head]
               && (now - stamp_mem[head]) > TIME_W'(window))
            evict_oldest();
        if (sent != '1)
            sent = sent + 1'b1;
        if (held >= WINDOW_DEPTH)
            evict_oldest();
        tail = PTR_W'((int'(head) + int'(held)) % WINDOW_DEPTH);
        stamp_mem[tail] = now;
        size_mem[tail]  = size;
        held = held + 1'b1;
        sum  = sum + SUM_W'(size);
        if (adapt_on && target != 0 && held >= 2
            && {1'b0, sent} >= {1'b0, adapted_at} + 33'(cooldown))
        begin
            first = stamp_mem[head];
            span  = (now > first) ? 64'(now - first) : 64'd0;
            if (span < 64'd1000)
                span = 64'd1000;
            wide_sum = 64'(sum) * 64'd800000;
            above    = 64'(target) * 64'd115 * span;
            below    = 64'(target) * 64'd85 * span;
            q = int'(q_now);
            if (wide_sum > above && q > int'(q_min))
            begin
                q = q - int'(q_step);
                if (q < int'(q_min))
                    q = int'(q_min);
                stepped = 1'b1;
            end
            else if (wide_sum < below && q < int'(q_max))
            begin
                q = q + int'(q_step);
                if (q > int'(q_max))
                    q = int'(q_max);
                stepped = 1'b1;
            end
            if (stepped)
            begin
                q_now      = Q_W'(q);
                adapted_at = sent;
            end
        end
        r.quality = q_now;
        r.changed = stepped;
        r.bytes   = sum;
        r.entries = held;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adapt_on   = 1'b0;
            target     = '0;
            q_min      = RST_MIN_QUALITY;
            q_max      = RST_MAX_QUALITY;
            q_step     = RST_QUALITY_STEP;
            cooldown   = RST_COOLDOWN_FRAMES;
            window     = RST_WINDOW_US;
            q_now      = RST_INITIAL_QUALITY;
            head       = '0;
            held       = '0;
            sum        = '0;
            sent       = '0;
            adapted_at = '0;
            put_idx    = '0;
            take_idx   = '0;
            mismatches      = 0;
            reports_pending = 0;
        end
        else
        begin
            if (cfg_write)
                apply_setting(cfg_index, cfg_data);
            if (out_valid && !out_stall)
            begin
                seen = {quality, quality_changed, window_bytes, window_entries};
                if (reports_pending == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: result transaction with no frame pending: ",
                                  "q=%0d chg=%0d bytes=%0d entries=%0d"},
                                 $time, seen.quality, seen.changed, seen.bytes,
                                 seen.entries);
                end
                else
                begin
                    want     = reports_due[take_idx];
                    take_idx = take_idx + 1'b1;
                    reports_pending--;
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch: expected q=%0d chg=%0d bytes=%0d ",
                                      "entries=%0d, got q=%0d chg=%0d bytes=%0d entries=%0d"},
                                     $time, want.quality, want.changed, want.bytes,
                                     want.entries, seen.quality, seen.changed,
                                     seen.bytes, seen.entries);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (reports_pending >= 16)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: too many frame transactions without a result",
                                 $time);
                end
                else
                begin
                    reports_due[put_idx] = predict_frame_result(time_us, byte_count);
                    put_idx = put_idx + 1'b1;
                    reports_pending++;
                end
            end
        end
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import aqbg_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [TIME_W-1:0]     time_us;
    logic [BYTES_W-1:0]    byte_count;
    logic                  out_valid;
    logic                  out_stall;
    logic [Q_W-1:0]        quality;
    logic                  quality_changed;
    logic [SUM_W-1:0]      window_bytes;
    logic [CNT_W-1:0]      window_entries;
    int                    mismatches;
    int                    reports_pending;

    int                    tx_idle_pct;
    int                    rx_idle_pct;
    logic [CFG_DATA_W-1:0] setting [8];
    logic [TIME_W-1:0]     stamp;
    logic [BYTES_W-1:0]    size;
    int                    dt_low;
    int                    dt_high;
    int                    pick;

    adaptive_quality_bandwidth_governor_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .time_us         (time_us),
        .byte_count      (byte_count),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .quality         (quality),
        .quality_changed (quality_changed),
        .window_bytes    (window_bytes),
        .window_entries  (window_entries)
    );

    governor_check governor_watch (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .time_us         (time_us),
        .byte_count      (byte_count),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .quality         (quality),
        .quality_changed (quality_changed),
        .window_bytes    (window_bytes),
        .window_entries  (window_entries),
        .mismatches      (mismatches),
        .reports_pending (reports_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] value, int width);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom;
        if ($urandom_range(0, 3) == 0)
            return value | (junk << width);
        return value;
    endfunction

    task automatic load_settings();
        for (int i = 0; i < 8; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= setting[i];
            @(negedge clk);
        end
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic push_frame(logic [TIME_W-1:0] t, logic [BYTES_W-1:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        time_us    <= t;
        byte_count <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (reports_pending != 0);
    endtask

    task automatic random_settings(int phase);
        setting[CFG_ADAPT_ENABLE] = with_junk(CFG_DATA_W'($urandom_range(0, 4) != 0), 1);
        case ($urandom_range(0, 9))
            0:       setting[CFG_TARGET_KBPS] = 0;
            1:       setting[CFG_TARGET_KBPS] = 20'hFFFFF;
            default: setting[CFG_TARGET_KBPS] = $urandom_range(200, 3000);
        endcase
        setting[CFG_TARGET_KBPS] = with_junk(setting[CFG_TARGET_KBPS], TARGET_W);
        setting[CFG_MIN_QUALITY] = with_junk($urandom_range(0, 40), Q_W);
        setting[CFG_MAX_QUALITY] = with_junk($urandom_range(50, 100), Q_W);
        if ($urandom_range(0, 7) == 0)
            setting[CFG_MIN_QUALITY] = with_junk($urandom_range(0, 100), Q_W);
        setting[CFG_QUALITY_STEP] = with_junk(($urandom_range(0, 5) == 0)
                                              ? $urandom_range(0, 100)
                                              : $urandom_range(1, 20), Q_W);
        setting[CFG_COOLDOWN_FRAMES] = with_junk(($urandom_range(0, 9) == 0)
                                                 ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 8), COOL_W);
        case ($urandom_range(0, 9))
            0:       setting[CFG_WINDOW_US] = $urandom;
            1:       setting[CFG_WINDOW_US] = $urandom_range(0, 20000);
            default: setting[CFG_WINDOW_US] = $urandom_range(50000, 2000000);
        endcase
        setting[CFG_INITIAL_QUALITY] = with_junk($urandom_range(0, 100), Q_W);
        if (phase == 3)
        begin
            setting[CFG_COOLDOWN_FRAMES] = 32'd65535;
            setting[CFG_WINDOW_US]       = 32'hFFFF_FFFF;
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        time_us     = '0;
        byte_count  = '0;
        tx_idle_pct = 13;
        rx_idle_pct = 79;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        setting[CFG_ADAPT_ENABLE]    = 1;
        setting[CFG_TARGET_KBPS]     = 1000;
        setting[CFG_MIN_QUALITY]     = 10;
        setting[CFG_MAX_QUALITY]     = 95;
        setting[CFG_QUALITY_STEP]    = 100;
        setting[CFG_COOLDOWN_FRAMES] = 0;
        setting[CFG_WINDOW_US]       = 100000;
        setting[CFG_INITIAL_QUALITY] = 50;
        load_settings();
        push_frame(48'd0, 24'd0);
        push_frame(48'd0, 24'hFFFFFF);
        push_frame(48'd500, 24'd0);
        push_frame(48'd200000, 24'd0);
        push_frame(48'd200001, 24'd1);
        push_frame(48'd100, 24'd5);
        push_frame(48'hFFFF_FFFF_FFFF, 24'hFFFFFF);
        push_frame(48'hFFFF_FFFF_FFFF, 24'd0);
        push_frame(48'h5555_5555_5555, 24'hAAAAAA);
        push_frame(48'hAAAA_AAAA_AAAA, 24'h555555);
        drain();

        setting[CFG_TARGET_KBPS]     = 32'hFFFFF;
        setting[CFG_MIN_QUALITY]     = 0;
        setting[CFG_MAX_QUALITY]     = 100;
        setting[CFG_QUALITY_STEP]    = 0;
        setting[CFG_COOLDOWN_FRAMES] = 3;
        setting[CFG_WINDOW_US]       = 0;
        load_settings();
        push_frame(48'd1000, 24'd100);
        push_frame(48'd1000, 24'd100);
        push_frame(48'd1000, 24'd100);
        push_frame(48'd1001, 24'd7);
        push_frame(48'd1001, 24'd7);
        push_frame(48'd1001, 24'd7);
        push_frame(48'd5000, 24'd1000);
        drain();

        setting[CFG_ADAPT_ENABLE]    = 0;
        setting[CFG_TARGET_KBPS]     = 1000;
        setting[CFG_MIN_QUALITY]     = 100;
        setting[CFG_MAX_QUALITY]     = 0;
        setting[CFG_QUALITY_STEP]    = 100;
        setting[CFG_COOLDOWN_FRAMES] = 0;
        setting[CFG_WINDOW_US]       = 32'hFFFF_FFFF;
        setting[CFG_INITIAL_QUALITY] = 100;
        load_settings();
        push_frame(48'd10, 24'hFFFFFF);
        push_frame(48'd20, 24'hFFFFFF);
        push_frame(48'd30, 24'd0);
        drain();

        setting[CFG_ADAPT_ENABLE] = 1;
        setting[CFG_TARGET_KBPS]  = 0;
        load_settings();
        push_frame(48'd40, 24'hFFFFFF);
        push_frame(48'd50, 24'd1);
        drain();

        stamp = 48'd1000000;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 2)
            begin
                tx_idle_pct = 79;
                rx_idle_pct = 13;
            end
            else if (phase == 4)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            random_settings(phase);
            load_settings();
            if ($urandom_range(0, 2) == 0)
            begin
                dt_low  = 0;
                dt_high = 3000;
            end
            else
            begin
                dt_low  = 5000;
                dt_high = 60000;
            end
            for (int n = 0; n < 100; n++)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    stamp = stamp - TIME_W'($urandom_range(0, 100000));
                else if (pick == 1)
                    stamp = TIME_W'({$urandom, $urandom});
                else if (pick == 2)
                    stamp = stamp + TIME_W'(setting[CFG_WINDOW_US])
                            + TIME_W'($urandom_range(1, 5000));
                else
                    stamp = stamp + TIME_W'($urandom_range(dt_low, dt_high));
                case ($urandom_range(0, 15))
                    0:       size = BYTES_W'($urandom);
                    1:       size = '0;
                    2:       size = '1;
                    default: size = BYTES_W'($urandom_range(200, 9000));
                endcase
                push_frame(stamp, size);
            end
            drain();
        end

        repeat (250) @(negedge clk);
        if (mismatches == 0 && reports_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
sv/aqbg_pkg.sv
sv/aqbg_ctrl.sv
sv/aqbg_dp.sv
sv/adaptive_quality_bandwidth_governor_top.sv
tb/sv/governor_check.sv
tb/sv/tb.sv
